// ===== rtl/core/pttt_pkg.sv =====
// package for the periodic task trigger table
// sizes, command codes, slot entry and write request types; no dependencies
package pttt_pkg;

  localparam int unsigned Slots      = 16;
  localparam int unsigned KeyBits    = 16;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned SlotW      = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  typedef enum logic [3:0] {
    CMD_REGISTER     = 4'd0,
    CMD_CLEAR_SLOT   = 4'd1,
    CMD_CLEAR_KEY    = 4'd2,
    CMD_ENABLE_SLOT  = 4'd3,
    CMD_ENABLE_KEY   = 4'd4,
    CMD_INTERVAL_SLOT = 4'd5,
    CMD_INTERVAL_KEY = 4'd6,
    CMD_TICK         = 4'd7,
    CMD_FIND         = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_REGISTER,
    WR_CLEAR,
    WR_ENABLE,
    WR_INTERVAL,
    WR_FIRE
  } wr_op_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_APPLY = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  typedef struct packed {
    logic [KeyBits-1:0] key;
    logic               en;
    logic [31:0]        ival;
    logic [31:0]        last_fire;
  } slot_entry_t;

  typedef struct packed {
    wr_op_e             op;
    logic [SlotW-1:0]   idx;
    logic [KeyBits-1:0] key;
    logic               en;
    logic [31:0]        ival;
    logic [31:0]        now;
  } wr_req_t;

  typedef struct packed {
    logic key_match;
    logic due;
  } eval_res_t;

endpackage

// ===== rtl/core/pttt_slot_table.sv =====
// slot table storage: key, enable, interval and last-fire per slot
// one read index, one write request per cycle; uses pttt_pkg
module pttt_slot_table
  import pttt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SlotW-1:0] rd_idx_i,
  output slot_entry_t      rd_entry_o,
  input  wr_req_t          wr_i
);

  logic [KeyBits-1:0] key_q  [Slots];
  logic               en_q   [Slots];
  logic [31:0]        ival_q [Slots];
  logic [31:0]        lf_q   [Slots];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) begin
        key_q[i]  <= '0;
        en_q[i]   <= 1'b0;
        ival_q[i] <= '0;
        lf_q[i]   <= '0;
      end
    end else begin
      case (wr_i.op)
        WR_REGISTER: begin
          key_q[wr_i.idx]  <= wr_i.key;
          en_q[wr_i.idx]   <= wr_i.en;
          ival_q[wr_i.idx] <= wr_i.ival;
        end
        WR_CLEAR: begin
          key_q[wr_i.idx]  <= '0;
          en_q[wr_i.idx]   <= 1'b0;
          ival_q[wr_i.idx] <= '0;
          lf_q[wr_i.idx]   <= '0;
        end
        WR_ENABLE:   en_q[wr_i.idx]   <= wr_i.en;
        WR_INTERVAL: ival_q[wr_i.idx] <= wr_i.ival;
        WR_FIRE:     lf_q[wr_i.idx]   <= wr_i.now;
        default: ;
      endcase
    end
  end

  assign rd_entry_o.key       = key_q[rd_idx_i];
  assign rd_entry_o.en        = en_q[rd_idx_i];
  assign rd_entry_o.ival      = ival_q[rd_idx_i];
  assign rd_entry_o.last_fire = lf_q[rd_idx_i];

endmodule

// ===== rtl/core/pttt_eval_unit.sv =====
// shared slot evaluator: key compare and elapsed-time due check
// one subtract and compare, reused for every slot of a scan; uses pttt_pkg
module pttt_eval_unit
  import pttt_pkg::*;
(
  input  slot_entry_t        entry_i,
  input  logic [KeyBits-1:0] key_i,
  input  logic [31:0]        now_i,
  output eval_res_t          res_o
);

  logic [31:0] elapsed;

  assign elapsed       = now_i - entry_i.last_fire;
  assign res_o.key_match = (entry_i.key == key_i);
  assign res_o.due     = (entry_i.key != '0) && entry_i.en && (elapsed >= entry_i.ival);

endmodule

// ===== rtl/core/periodic_task_trigger_table_unit.sv =====
// top level of the periodic task trigger table: command sequencer and outputs
// instantiates pttt_slot_table and pttt_eval_unit; uses pttt_pkg
//
// usage:
//   a command transaction is taken at a rising edge with start high and busy
//   low; busy stays high until the last result of that command is shown.
//   results appear on ok_o, found_slot_o, fired_key_o, last_o for one cycle
//   each, marked by valid_o; last_o flags the final result of a command.
//   slot commands give their single result from ST_APPLY, or from ST_FLUSH
//   for a bad slot, through the output registers. key commands walk the
//   table one slot per cycle through the shared evaluator. a tick walks all
//   Slots entries, with fired results spread along the walk and the final
//   one at the end, or earlier once MaxResults slots have fired. the walk
//   length sets the throughput.
//   failures (bad slot, key not found, unknown code) give one result with ok 0.
//   reset clears the whole table and the sequencer at once; the receiver
//   cannot stall, so every result is taken in the cycle it is shown.
module periodic_task_trigger_table_unit
  import pttt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  command_i,
  input  logic [7:0]  slot_i,
  input  logic [15:0] task_key_i,
  input  logic [31:0] interval_ms_i,
  input  logic        enable_i,
  input  logic [31:0] now_ms_i,
  output logic        valid_o,
  output logic        ok_o,
  output logic [7:0]  found_slot_o,
  output logic [15:0] fired_key_o,
  output logic        last_o
);

  state_e             state_q, state_d;
  logic [3:0]         cmd_q, cmd_d;
  logic [KeyBits-1:0] key_q, key_d;
  logic [31:0]        ival_q, ival_d;
  logic               en_q, en_d;
  logic [31:0]        now_q, now_d;
  logic [SlotW-1:0]   idx_q, idx_d;
  logic [SlotW-1:0]   pos_q, pos_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [CntW-1:0]    cnt_next;
  logic               pend_vld_q, pend_vld_d;
  logic [SlotW-1:0]   pend_slot_q, pend_slot_d;
  logic [15:0]        pend_key_q, pend_key_d;
  logic               vld_q, vld_d;
  logic               ok_q, ok_d;
  logic [7:0]         slot_q, slot_d;
  logic [15:0]        fkey_q, fkey_d;
  logic               last_q, last_d;
  logic               last_scan;
  slot_entry_t        entry;
  eval_res_t          ev;
  wr_req_t            wr;

  pttt_slot_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (idx_q),
    .rd_entry_o (entry),
    .wr_i       (wr)
  );

  pttt_eval_unit u_eval (
    .entry_i (entry),
    .key_i   (key_q),
    .now_i   (now_q),
    .res_o   (ev)
  );

  assign last_scan = (idx_q == SlotW'(Slots - 1));
  assign cnt_next  = cnt_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    ival_d      = ival_q;
    en_d        = en_q;
    now_d       = now_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    pend_vld_d  = pend_vld_q;
    pend_slot_d = pend_slot_q;
    pend_key_d  = pend_key_q;
    vld_d       = 1'b0;
    ok_d        = ok_q;
    slot_d      = slot_q;
    fkey_d      = fkey_q;
    last_d      = last_q;
    wr          = '0;
    wr.op       = WR_NONE;
    wr.idx      = pos_q;
    wr.key      = key_q;
    wr.en       = en_q;
    wr.ival     = ival_q;
    wr.now      = now_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_d      = command_i;
          key_d      = KeyBits'(task_key_i);
          ival_d     = interval_ms_i;
          en_d       = enable_i;
          now_d      = now_ms_i;
          idx_d      = '0;
          cnt_d      = '0;
          pend_vld_d = 1'b0;
          unique case (command_i)
            CMD_REGISTER, CMD_CLEAR_SLOT, CMD_ENABLE_SLOT, CMD_INTERVAL_SLOT: begin
              if (slot_i < 8'(Slots)) begin
                pos_d   = slot_i[SlotW-1:0];
                state_d = ST_APPLY;
              end else begin
                state_d = ST_FLUSH;
              end
            end
            CMD_CLEAR_KEY, CMD_ENABLE_KEY, CMD_INTERVAL_KEY, CMD_TICK, CMD_FIND: begin
              state_d = ST_SCAN;
            end
            default: state_d = ST_FLUSH;
          endcase
        end
      end
      ST_SCAN: begin
        idx_d = idx_q + 1'b1;
        if (cmd_q == CMD_TICK) begin
          if (ev.due) begin
            wr.op  = WR_FIRE;
            wr.idx = idx_q;
            if (pend_vld_q) begin
              vld_d  = 1'b1;
              ok_d   = 1'b1;
              slot_d = 8'(pend_slot_q);
              fkey_d = pend_key_q;
              last_d = 1'b0;
            end
            pend_vld_d  = 1'b1;
            pend_slot_d = idx_q;
            pend_key_d  = 16'(entry.key);
            cnt_d       = cnt_next;
            if (last_scan || cnt_next == CntW'(MaxResults)) begin
              state_d = ST_FLUSH;
            end
          end else if (last_scan) begin
            state_d = ST_FLUSH;
          end
        end else begin
          if (ev.key_match) begin
            pos_d   = idx_q;
            state_d = ST_APPLY;
          end else if (last_scan) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_APPLY: begin
        unique case (cmd_q)
          CMD_REGISTER:                      wr.op = WR_REGISTER;
          CMD_CLEAR_SLOT, CMD_CLEAR_KEY:       wr.op = WR_CLEAR;
          CMD_ENABLE_SLOT, CMD_ENABLE_KEY:     wr.op = WR_ENABLE;
          CMD_INTERVAL_SLOT, CMD_INTERVAL_KEY: wr.op = WR_INTERVAL;
          default:                           wr.op = WR_NONE;
        endcase
        vld_d   = 1'b1;
        ok_d    = 1'b1;
        slot_d  = 8'(pos_q);
        fkey_d  = '0;
        last_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_FLUSH: begin
        vld_d   = 1'b1;
        ok_d    = pend_vld_q;
        slot_d  = pend_vld_q ? 8'(pend_slot_q) : 8'd0;
        fkey_d  = pend_vld_q ? pend_key_q : 16'd0;
        last_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      vld_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      cnt_q      <= '0;
      idx_q      <= '0;
    end else begin
      state_q    <= state_d;
      vld_q      <= vld_d;
      pend_vld_q <= pend_vld_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    key_q       <= key_d;
    ival_q      <= ival_d;
    en_q        <= en_d;
    now_q       <= now_d;
    pos_q       <= pos_d;
    pend_slot_q <= pend_slot_d;
    pend_key_q  <= pend_key_d;
    ok_q        <= ok_d;
    slot_q      <= slot_d;
    fkey_q      <= fkey_d;
    last_q      <= last_d;
  end

  assign busy         = (state_q != ST_IDLE);
  assign valid_o      = vld_q;
  assign ok_o         = ok_q;
  assign found_slot_o = slot_q;
  assign fired_key_o  = fkey_q;
  assign last_o       = last_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("sequencer state not one-hot");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted command did not raise busy");

  a_mid_is_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> ok_o) else $error("non-final result without a fire");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ok_o |-> found_slot_o == 8'd0 && fired_key_o == 16'd0)
    else $error("failed result carries slot or key");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy)) else $error("result without a command in flight");

endmodule

// ===== sim/periodic_task_trigger_table_unit_tb.sv =====
// self-checking testbench for periodic_task_trigger_table_unit
// predicts every result from its own copy of the slot table; uses pttt_pkg
`timescale 1ns / 100ps

module periodic_task_trigger_table_unit_tb;
  import pttt_pkg::*;

  localparam logic [3:0] CmdUnusedLo = 4'd9;
  localparam logic [3:0] CmdUnusedHi = 4'd15;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned KeyPool    = 6;

  typedef struct packed {
    logic        ok;
    logic [7:0]  slot;
    logic [15:0] key;
    logic        last;
  } table_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [3:0]  command_i;
  logic [7:0]  slot_i;
  logic [15:0] task_key_i;
  logic [31:0] interval_ms_i;
  logic        enable_i;
  logic [31:0] now_ms_i;
  logic        valid_o;
  logic        ok_o;
  logic [7:0]  found_slot_o;
  logic [15:0] fired_key_o;
  logic        last_o;

  logic [KeyBits-1:0] key_tbl  [Slots];
  logic               en_tbl   [Slots];
  logic [31:0]        ival_tbl [Slots];
  logic [31:0]        fire_tbl [Slots];

  table_result_t pending_results[$];
  logic [15:0]   key_pool[KeyPool];
  logic [31:0]   tick_now;
  bit            idle_enable;
  int unsigned   cycle_count;
  int unsigned   items_sent;
  int unsigned   results_checked;
  int unsigned   fires_seen;
  int unsigned   error_count;

  periodic_task_trigger_table_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .command_i    (command_i),
    .slot_i       (slot_i),
    .task_key_i   (task_key_i),
    .interval_ms_i(interval_ms_i),
    .enable_i     (enable_i),
    .now_ms_i     (now_ms_i),
    .valid_o      (valid_o),
    .ok_o         (ok_o),
    .found_slot_o (found_slot_o),
    .fired_key_o  (fired_key_o),
    .last_o       (last_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("periodic_task_trigger_table_unit_tb: done, errors");
      $finish;
    end
  end

  function automatic table_result_t make_result(logic ok, int unsigned slot,
                                                logic [15:0] key, logic last);
    table_result_t r;
    r.ok   = ok;
    r.slot = 8'(slot);
    r.key  = key;
    r.last = last;
    return r;
  endfunction

  task automatic predict_table_results(input logic [3:0] cmd, input logic [7:0] slot,
                                       input logic [15:0] key, input logic [31:0] ival,
                                       input logic en, input logic [31:0] now);
    logic [KeyBits-1:0] k;
    int                 pos;
    int                 n_fired;
    int                 fired_slots[MaxResults];
    k       = key[KeyBits-1:0];
    pos     = -1;
    n_fired = 0;
    if (cmd == CMD_TICK) begin
      for (int s = 0; s < Slots && n_fired < MaxResults; s++) begin
        if (key_tbl[s] != '0 && en_tbl[s] && (now - fire_tbl[s]) >= ival_tbl[s]) begin
          fire_tbl[s] = now;
          fired_slots[n_fired] = s;
          n_fired++;
        end
      end
      if (n_fired == 0) begin
        pending_results.push_back(make_result(1'b0, 0, 16'h0, 1'b1));
      end else begin
        for (int i = 0; i < n_fired; i++) begin
          pending_results.push_back(make_result(1'b1, fired_slots[i],
                                                16'(key_tbl[fired_slots[i]]),
                                                i == n_fired - 1));
        end
      end
    end else begin
      case (cmd)
        CMD_REGISTER, CMD_CLEAR_SLOT, CMD_ENABLE_SLOT, CMD_INTERVAL_SLOT: begin
          if (slot < Slots) pos = slot;
        end
        CMD_CLEAR_KEY, CMD_ENABLE_KEY, CMD_INTERVAL_KEY, CMD_FIND: begin
          for (int s = Slots - 1; s >= 0; s--) begin
            if (key_tbl[s] == k) pos = s;
          end
        end
        default: pos = -1;
      endcase
      if (pos < 0) begin
        pending_results.push_back(make_result(1'b0, 0, 16'h0, 1'b1));
      end else begin
        case (cmd)
          CMD_REGISTER: begin
            key_tbl[pos]  = k;
            en_tbl[pos]   = en;
            ival_tbl[pos] = ival;
          end
          CMD_CLEAR_SLOT, CMD_CLEAR_KEY: begin
            key_tbl[pos]  = '0;
            en_tbl[pos]   = 1'b0;
            ival_tbl[pos] = '0;
            fire_tbl[pos] = '0;
          end
          CMD_ENABLE_SLOT, CMD_ENABLE_KEY: en_tbl[pos] = en;
          CMD_INTERVAL_SLOT, CMD_INTERVAL_KEY: ival_tbl[pos] = ival;
          default: ;
        endcase
        pending_results.push_back(make_result(1'b1, pos, 16'h0, 1'b1));
      end
    end
  endtask

  // start stays high across back-to-back transactions
  task automatic send_command(input logic [3:0] cmd, input logic [7:0] slot,
                              input logic [15:0] key, input logic [31:0] ival,
                              input logic en, input logic [31:0] now);
    int unsigned gap;
    if (idle_enable && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start         <= 1'b1;
    command_i     <= cmd;
    slot_i        <= slot;
    task_key_i    <= key;
    interval_ms_i <= ival;
    enable_i      <= en;
    now_ms_i      <= now;
    do @(posedge clk_i); while (busy);
    predict_table_results(cmd, slot, key, ival, en, now);
    items_sent++;
  endtask

  always @(posedge clk_i) begin
    table_result_t exp;
    if (rst_ni && valid_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: ok %0b slot %0d key %h last %0b",
               ok_o, found_slot_o, fired_key_o, last_o);
        error_count++;
      end else begin
        exp = pending_results.pop_front();
        results_checked++;
        if (ok_o && fired_key_o != 16'h0) fires_seen++;
        if (ok_o !== exp.ok) begin
          $error("ok: expected %0b, actual %0b", exp.ok, ok_o);
          error_count++;
        end
        if (found_slot_o !== exp.slot) begin
          $error("found_slot: expected %0d, actual %0d", exp.slot, found_slot_o);
          error_count++;
        end
        if (fired_key_o !== exp.key) begin
          $error("fired_key: expected %h, actual %h", exp.key, fired_key_o);
          error_count++;
        end
        if (last_o !== exp.last) begin
          $error("last: expected %0b, actual %0b", exp.last, last_o);
          error_count++;
        end
      end
    end
  end

  function automatic logic [15:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return key_pool[$urandom_range(0, KeyPool - 1)];
    if (r < 95) return 16'($urandom);
    return 16'h0;
  endfunction

  function automatic logic [7:0] pick_slot();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, Slots - 1));
  endfunction

  function automatic logic [31:0] pick_interval();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 40);
    if (r < 90) return $urandom_range(0, 1000);
    return $urandom;
  endfunction

  task automatic test_slot_addressed();
    send_command(CMD_REGISTER, 8'd0, 16'hFFFF, 32'd0, 1'b1, 32'd0);
    send_command(CMD_REGISTER, 8'(Slots - 1), 16'h0001, 32'hFFFF_FFFF, 1'b0, 32'd0);
    send_command(CMD_REGISTER, 8'(Slots), 16'h1234, 32'd7, 1'b1, 32'd0);
    send_command(CMD_ENABLE_SLOT, 8'd255, 16'h0, 32'd0, 1'b1, 32'd0);
    send_command(CMD_ENABLE_SLOT, 8'(Slots - 1), 16'h0, 32'd0, 1'b1, 32'd0);
    send_command(CMD_INTERVAL_SLOT, 8'd0, 16'h0, 32'd5, 1'b0, 32'd0);
    send_command(CMD_CLEAR_SLOT, 8'(Slots - 1), 16'h0, 32'd0, 1'b0, 32'd0);
    send_command(CMD_REGISTER, 8'd3, 16'h0000, 32'd9, 1'b1, 32'd0);
    send_command(CmdUnusedLo, 8'd0, 16'hFFFF, 32'd0, 1'b1, 32'd0);
    send_command(CmdUnusedHi, 8'd1, 16'h0001, 32'd0, 1'b1, 32'd0);
  endtask

  task automatic test_key_addressed();
    send_command(CMD_FIND, 8'd0, 16'hFFFF, 32'd0, 1'b0, 32'd0);
    send_command(CMD_FIND, 8'd0, 16'h0000, 32'd0, 1'b0, 32'd0);
    send_command(CMD_FIND, 8'd0, 16'h1234, 32'd0, 1'b0, 32'd0);
    send_command(CMD_ENABLE_KEY, 8'd0, 16'hFFFF, 32'd0, 1'b0, 32'd0);
    send_command(CMD_INTERVAL_KEY, 8'd0, 16'hFFFF, 32'd3, 1'b0, 32'd0);
    send_command(CMD_INTERVAL_KEY, 8'd0, 16'h7777, 32'd3, 1'b0, 32'd0);
    send_command(CMD_CLEAR_KEY, 8'd0, 16'hFFFF, 32'd0, 1'b0, 32'd0);
    send_command(CMD_CLEAR_KEY, 8'd0, 16'h1234, 32'd0, 1'b0, 32'd0);
  endtask

  task automatic test_tick_due_times();
    send_command(CMD_REGISTER, 8'd2, 16'h00AA, 32'd10, 1'b1, 32'd0);
    send_command(CMD_REGISTER, 8'd4, 16'h5500, 32'hFFFF_FFFF, 1'b1, 32'd0);
    send_command(CMD_REGISTER, 8'd6, 16'h0F0F, 32'd0, 1'b0, 32'd0);
    send_command(CMD_TICK, 8'd0, 16'h0, 32'd0, 1'b0, 32'd5);
    send_command(CMD_TICK, 8'd0, 16'h0, 32'd0, 1'b0, 32'd10);
    send_command(CMD_TICK, 8'd0, 16'h0, 32'd0, 1'b0, 32'hFFFF_FFFF);
    send_command(CMD_TICK, 8'd0, 16'h0, 32'd0, 1'b0, 32'd0);
    // time wraps past zero since the last firing
    send_command(CMD_TICK, 8'd0, 16'h0, 32'd0, 1'b0, 32'd9);
  endtask

  task automatic test_full_table_tick();
    logic [31:0] now;
    now = $urandom;
    for (int s = 0; s < Slots; s++) begin
      send_command(CMD_REGISTER, 8'(s), 16'($urandom_range(1, 16'hFFFF)), 32'd0, 1'b1,
                   32'd0);
    end
    send_command(CMD_TICK, 8'd0, 16'h0, 32'd0, 1'b0, now);
    send_command(CMD_TICK, 8'd0, 16'h0, 32'd0, 1'b0, now);
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned r;
    logic [3:0]  cmd;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 22)      cmd = CMD_REGISTER;
      else if (r < 47) cmd = CMD_TICK;
      else if (r < 55) cmd = CMD_FIND;
      else if (r < 61) cmd = CMD_ENABLE_SLOT;
      else if (r < 67) cmd = CMD_ENABLE_KEY;
      else if (r < 73) cmd = CMD_INTERVAL_SLOT;
      else if (r < 79) cmd = CMD_INTERVAL_KEY;
      else if (r < 86) cmd = CMD_CLEAR_SLOT;
      else if (r < 93) cmd = CMD_CLEAR_KEY;
      else if (r < 96) cmd = 4'($urandom_range(CmdUnusedLo, CmdUnusedHi));
      else             cmd = 4'($urandom_range(0, 15));
      if (cmd == CMD_TICK) begin
        if ($urandom_range(0, 9) == 0) tick_now = $urandom;
        else tick_now = tick_now + $urandom_range(0, 15);
        send_command(cmd, 8'($urandom), 16'($urandom), $urandom, 1'($urandom), tick_now);
      end else begin
        send_command(cmd, pick_slot(), pick_key(), pick_interval(),
                     $urandom_range(0, 9) < 8, $urandom);
      end
    end
  endtask

  initial begin
    start         = 1'b0;
    rst_ni        = 1'b0;
    command_i     = CMD_FIND;
    slot_i        = 8'd0;
    task_key_i    = 16'h0;
    interval_ms_i = 32'd0;
    enable_i      = 1'b0;
    now_ms_i      = 32'd0;
    idle_enable   = 1'b0;
    tick_now      = $urandom;
    foreach (key_tbl[s]) begin
      key_tbl[s]  = '0;
      en_tbl[s]   = 1'b0;
      ival_tbl[s] = '0;
      fire_tbl[s] = '0;
    end
    foreach (key_pool[i]) key_pool[i] = 16'($urandom_range(1, 16'hFFFF));
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_slot_addressed();
    test_key_addressed();
    idle_enable = 1'b1;
    test_tick_due_times();
    test_full_table_tick();
    test_random_traffic(280);
    idle_enable = 1'b0;
    test_random_traffic(40);

    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Slots + 4) @(posedge clk_i);

    $display("covered slot, key, tick and unused commands: %0d transactions, %0d results",
             items_sent, results_checked);
    $display("%0d slot firings checked, %0d mismatches", fires_seen, error_count);
    if (error_count == 0) begin
      $display("periodic_task_trigger_table_unit_tb: done, clean");
    end else begin
      $display("periodic_task_trigger_table_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
